/* hdl/utfv_pkg.sv */
// Shared types and constants for the UTF-8 stream validator.
// Used by utfv_step, utfv_outbuf and utf8_stream_validator; depends on nothing.
package utfv_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int CHAR_COUNT_W = 32;
    localparam int MAX_RESULTS  = 3;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_BAD     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Byte classification constants.
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;
    localparam logic [7:0] PAYLOAD_MASK = 8'h3F;
    localparam logic [7:0] LEAD_BIT     = 8'h40;
    localparam logic [2:0] LONG_SEQ     = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [1:0]              result_kind;
        logic [30:0]             code_point;
        logic [CHAR_COUNT_W-1:0] char_count;
        logic                    all_valid;
        logic                    last_result;
    } t_out;

    typedef struct packed {
        logic [2:0]             bytes_pending;
        logic [2:0]             lead_ones;
        logic [30:0]            partial_code;
        logic                   string_ok;
        logic [COUNT_WIDTH-1:0] valid_count;
        logic                   skip_to_end;
    } t_state;

    // All results caused by one byte, packed from slot 0 upward.
    typedef struct packed {
        logic [1:0]                  n;
        t_out [MAX_RESULTS-1:0]      res;
    } t_batch;

endpackage

/* hdl/utfv_step.sv */
// Combinational per-byte decode step: string state plus one byte in,
// next state plus up to three results out. Depends on utfv_pkg.
module utfv_step (
    input  utfv_pkg::t_state i_state,
    input  utfv_pkg::t_in    i_data,
    output utfv_pkg::t_state o_next_state,
    output utfv_pkg::t_batch o_batch
);

    function automatic logic [2:0] lead_conts(input logic [7:0] b);
        logic [2:0] cnt;
        logic       run;
        cnt = '0;
        run = 1'b1;
        for (int i = 6; i >= 0; i--) begin
            if (run && b[i]) begin
                cnt = cnt + 3'd1;
            end else begin
                run = 1'b0;
            end
        end
        return cnt;
    endfunction

    function automatic utfv_pkg::t_out mk_out(input logic [1:0] kind,
                                              input logic [30:0] cp,
                                              input utfv_pkg::t_state s);
        utfv_pkg::t_out o;
        o.result_kind = kind;
        o.code_point  = cp;
        o.char_count  = utfv_pkg::CHAR_COUNT_W'(s.valid_count);
        o.all_valid   = s.string_ok;
        o.last_result = 1'b0;
        return o;
    endfunction

    function automatic utfv_pkg::t_state clear_str(input utfv_pkg::t_state s);
        utfv_pkg::t_state c;
        c               = s;
        c.bytes_pending = '0;
        c.lead_ones     = '0;
        c.partial_code  = '0;
        c.string_ok     = 1'b1;
        c.valid_count   = '0;
        return c;
    endfunction

    utfv_pkg::t_state st;
    utfv_pkg::t_out [utfv_pkg::MAX_RESULTS-1:0] res;
    logic [1:0] n;
    logic       ended;
    logic       cont;
    logic [7:0] b;

    assign b    = i_data.data_byte;
    assign cont = ((b & utfv_pkg::CONT_MASK) == utfv_pkg::CONT_TAG);

    always_comb begin
        st    = i_state;
        res   = '0;
        n     = '0;
        ended = 1'b0;
        if (st.skip_to_end) begin
            if (i_data.end_of_string) begin
                st.skip_to_end = 1'b0;
            end
        end else begin
            if (st.bytes_pending != 3'd0 && cont) begin
                st.partial_code  = {st.partial_code[24:0], 6'(b & utfv_pkg::PAYLOAD_MASK)};
                st.bytes_pending = st.bytes_pending - 3'd1;
                if (st.bytes_pending == 3'd0) begin
                    if (st.lead_ones >= utfv_pkg::LONG_SEQ) begin
                        st.string_ok = 1'b0;
                        res[n] = mk_out(utfv_pkg::KIND_BAD, '0, st);
                    end else begin
                        if (st.valid_count != '1) begin
                            st.valid_count = st.valid_count + utfv_pkg::COUNT_WIDTH'(1);
                        end
                        res[n] = mk_out(utfv_pkg::KIND_CHAR, st.partial_code, st);
                    end
                    n               = n + 2'd1;
                    st.lead_ones    = '0;
                    st.partial_code = '0;
                end
            end else begin
                // A sequence cut short by a non-continuation byte.
                if (st.bytes_pending != 3'd0) begin
                    st.string_ok     = 1'b0;
                    res[n]           = mk_out(utfv_pkg::KIND_BAD, '0, st);
                    n                = n + 2'd1;
                    st.bytes_pending = '0;
                    st.lead_ones     = '0;
                    st.partial_code  = '0;
                end
                if (b == 8'd0) begin
                    res[n] = mk_out(utfv_pkg::KIND_SUMMARY, '0, st);
                    n      = n + 2'd1;
                    st     = clear_str(st);
                    ended  = 1'b1;
                end else if (!b[7]) begin
                    if (st.valid_count != '1) begin
                        st.valid_count = st.valid_count + utfv_pkg::COUNT_WIDTH'(1);
                    end
                    res[n] = mk_out(utfv_pkg::KIND_CHAR, 31'(b), st);
                    n      = n + 2'd1;
                end else if (cont) begin
                    st.string_ok = 1'b0;
                    res[n]       = mk_out(utfv_pkg::KIND_BAD, '0, st);
                    n            = n + 2'd1;
                end else begin
                    st.bytes_pending = lead_conts(b);
                    st.lead_ones     = lead_conts(b);
                    st.partial_code  = 31'(b & (utfv_pkg::PAYLOAD_MASK >> lead_conts(b)));
                end
            end
            if (ended) begin
                if (!i_data.end_of_string) begin
                    st.skip_to_end = 1'b1;
                end
            end else if (i_data.end_of_string) begin
                if (st.bytes_pending != 3'd0) begin
                    st.string_ok = 1'b0;
                    res[n]       = mk_out(utfv_pkg::KIND_BAD, '0, st);
                    n            = n + 2'd1;
                end
                res[n] = mk_out(utfv_pkg::KIND_SUMMARY, '0, st);
                n      = n + 2'd1;
                st     = clear_str(st);
            end
        end
        if (n != 2'd0) begin
            res[2'(n - 2'd1)].last_result = 1'b1;
        end
    end

    assign o_next_state = st;
    assign o_batch.n    = n;
    assign o_batch.res  = res;

endmodule

/* hdl/utfv_outbuf.sv */
// Result register: holds the results of one byte and presents them one
// transfer at a time. Depends on utfv_pkg.
module utfv_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  utfv_pkg::t_batch i_batch,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output utfv_pkg::t_out   o_result
);

    utfv_pkg::t_out [utfv_pkg::MAX_RESULTS-1:0] r_slot;
    logic [1:0] r_n;
    logic [1:0] r_idx;
    logic       drain;
    logic       drain_last;

    assign o_valid    = (r_idx < r_n);
    assign drain      = o_valid && i_ready;
    assign drain_last = drain && (r_idx == 2'(r_n - 2'd1));
    assign o_can_load = !o_valid || drain_last;
    assign o_result   = r_slot[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_n   <= i_batch.n;
            r_idx <= '0;
        end else if (drain_last) begin
            r_n   <= '0;
            r_idx <= '0;
        end else if (drain) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_batch.res;
        end
    end

endmodule

/* hdl/utf8_stream_validator.sv */
// Top level of the UTF-8 stream validator.
// Depends on utfv_pkg, utfv_step and utfv_outbuf.

// The validator takes one string byte per transfer and returns, for each
// byte, zero to three results: a decoded character, a malformed-sequence
// report, or an end-of-string summary carrying the saturating character
// count and the all-valid flag. A byte is held in an input register, decoded
// in one pass of shallow logic against the string state, and its results are
// written together into a three-slot result register that presents them one
// transfer per cycle while the downstream side takes them. A held byte is
// decoded, and its results loaded, once the result register can take them.
// Bytes that give at most one result are accepted every cycle as long as the
// downstream side takes every result; a byte that gives two or three results
// keeps the next byte waiting in the input register until its last result is
// taken, since the result register issues at most one result per cycle. Bytes
// skipped after a NUL give no results and pass at one per cycle while the
// result register is empty or draining its last result.
module utf8_stream_validator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  utfv_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output utfv_pkg::t_out o_result
);

    // Input register. Its payload needs no reset; only the valid flag does.
    logic             r_in_valid;
    utfv_pkg::t_in    r_in;

    // String state carried from byte to byte.
    utfv_pkg::t_state r_state;
    utfv_pkg::t_state n_state;

    utfv_pkg::t_batch batch;
    logic             can_load;
    logic             process;

    // A held byte is decoded once the result register can take its results.
    assign process = r_in_valid && can_load;
    // The input register frees up in the same cycle its byte is decoded.
    assign o_ready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    utfv_step u_step (
        .i_state      (r_state),
        .i_data       (r_in),
        .o_next_state (n_state),
        .o_batch      (batch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.bytes_pending <= '0;
            r_state.lead_ones     <= '0;
            r_state.partial_code  <= '0;
            r_state.string_ok     <= 1'b1;
            r_state.valid_count   <= '0;
            r_state.skip_to_end   <= 1'b0;
        end else if (process) begin
            r_state <= n_state;
        end
    end

    utfv_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (process),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    // Skipping after a NUL only starts from a cleared string, so no sequence
    // can be in flight while bytes are being discarded.
    a_skip_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip_to_end |-> (r_state.bytes_pending == 3'd0))
        else $error("skip_to_end set while continuation bytes are pending");

    // The pending count never exceeds the length announced by the lead byte.
    a_pending_le_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_pending <= r_state.lead_ones)
        else $error("bytes_pending exceeds lead_ones");

    // A summary always closes the results of its byte.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.result_kind == utfv_pkg::KIND_SUMMARY)
            |-> o_result.last_result)
        else $error("summary result not marked as the last of its byte");

endmodule

/* dv/utf8_stream_validator_tb.sv */
// Self-checking testbench for utf8_stream_validator: drives byte transfers and
// checks every result against a decoder model kept in the scoreboard class.
// Depends on utfv_pkg and the utf8_stream_validator RTL.
module utf8_stream_validator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The run stops here if results stop arriving.
    localparam int unsigned CYCLE_LIMIT  = 40000;
    // Number of random bytes offered after the directed strings.
    localparam int unsigned RANDOM_BYTES = 290;
    // Results pass through the input register and the result register, so a short drain suffices.
    localparam int unsigned DRAIN_CYCLES = 12;
    // Length of the one long receiver hold-off that backs up the pipeline.
    localparam int unsigned HOLD_CYCLES  = 80;
    // Percentage of cycles in which either side idles.
    localparam int unsigned IDLE_PCT     = 11;

    // The scoreboard decodes every accepted byte the way the block should and
    // keeps the results it must produce, oldest first.
    class utf8_scoreboard;
        logic [2:0]                       conts_left;
        logic [2:0]                       conts_total;
        logic [30:0]                      code_acc;
        bit                               str_ok;
        logic [utfv_pkg::COUNT_WIDTH-1:0] good_chars;
        bit                               skipping;
        utfv_pkg::t_out                   awaited[$];
        int unsigned                      n_errors;
        int unsigned                      n_checked;

        function new();
            clear_string();
            skipping  = 1'b0;
            n_errors  = 0;
            n_checked = 0;
        endfunction

        function void clear_string();
            conts_left  = '0;
            conts_total = '0;
            code_acc    = '0;
            str_ok      = 1'b1;
            good_chars  = '0;
        endfunction

        function void push_result(logic [1:0] kind, logic [30:0] cp);
            utfv_pkg::t_out r;
            r.result_kind = kind;
            r.code_point  = cp;
            r.char_count  = good_chars;
            r.all_valid   = str_ok;
            r.last_result = 1'b0;
            awaited.push_back(r);
        endfunction

        function void flag_malformed();
            str_ok = 1'b0;
            push_result(utfv_pkg::KIND_BAD, '0);
        endfunction

        function void add_char(logic [30:0] cp);
            // The count sticks at its maximum instead of wrapping.
            if (good_chars != '1)
                good_chars++;
            push_result(utfv_pkg::KIND_CHAR, cp);
        endfunction

        function void close_string();
            push_result(utfv_pkg::KIND_SUMMARY, '0);
            clear_string();
        endfunction

        // Handles a byte that opens a character; returns 1 when a NUL ended
        // the string.
        function bit begin_char(logic [7:0] b);
            logic [7:0] t;
            int         n;
            if (b == 8'h00) begin
                close_string();
                return 1'b1;
            end
            if (b[7] == 1'b0) begin
                add_char({23'd0, b});
            end else if ((b & utfv_pkg::CONT_MASK) == utfv_pkg::CONT_TAG) begin
                flag_malformed();
            end else begin
                // Count the ones below the top bit; 0xFF gives seven.
                n = 0;
                t = b;
                while ((t & utfv_pkg::LEAD_BIT) != 8'h00) begin
                    n++;
                    t = t << 1;
                end
                conts_left  = 3'(n);
                conts_total = 3'(n);
                code_acc    = {23'd0, b & (utfv_pkg::PAYLOAD_MASK >> n)};
            end
            return 1'b0;
        endfunction

        // Notes one accepted byte and queues the results it must cause.
        function void note_byte(utfv_pkg::t_in item);
            logic [7:0]     b;
            bit             last_byte;
            bit             ended;
            int             n_before;
            utfv_pkg::t_out r;
            b         = item.data_byte;
            last_byte = item.end_of_string;
            ended     = 1'b0;
            n_before  = awaited.size();
            if (skipping) begin
                if (last_byte)
                    skipping = 1'b0;
                return;
            end
            if (conts_left != 0 && (b & utfv_pkg::CONT_MASK) == utfv_pkg::CONT_TAG) begin
                code_acc = {code_acc[24:0], b[5:0]};
                conts_left--;
                if (conts_left == 0) begin
                    if (conts_total >= utfv_pkg::LONG_SEQ)
                        flag_malformed();
                    else
                        add_char(code_acc);
                    conts_total = '0;
                    code_acc    = '0;
                end
            end else begin
                if (conts_left != 0) begin
                    flag_malformed();
                    conts_left  = '0;
                    conts_total = '0;
                    code_acc    = '0;
                end
                ended = begin_char(b);
            end
            if (ended) begin
                if (!last_byte)
                    skipping = 1'b1;
            end else if (last_byte) begin
                if (conts_left != 0)
                    flag_malformed();
                close_string();
            end
            if (awaited.size() > n_before) begin
                r = awaited.pop_back();
                r.last_result = 1'b1;
                awaited.push_back(r);
            end
        endfunction

        task report(string msg);
            if (n_errors < 40)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            n_errors++;
        endtask

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                 n_checked, field, got, want));
        endtask

        // Compares one transferred result with the oldest queued one.
        task check_result(utfv_pkg::t_out got);
            utfv_pkg::t_out want;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d arrived with none pending (kind %0d)",
                                 n_checked, got.result_kind));
            end else begin
                want = awaited.pop_front();
                compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
                compare_field("code_point", 32'(got.code_point), 32'(want.code_point));
                compare_field("char_count", 32'(got.char_count), 32'(want.char_count));
                compare_field("all_valid", 32'(got.all_valid), 32'(want.all_valid));
                compare_field("last_result", 32'(got.last_result), 32'(want.last_result));
            end
            n_checked++;
        endtask

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    utfv_pkg::t_in  i_data;
    logic           o_valid;
    logic           i_ready;
    utfv_pkg::t_out o_result;

    utf8_scoreboard sb = new();

    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;
    // Both sides run without idling while this is set.
    logic        no_idle = 1'b0;
    // The receiver refuses every result while this is set.
    logic        hold_rx = 1'b0;

    utf8_stream_validator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Both handshakes are sampled at the rising edge, before any of the
    // nonblocking updates made at that edge take effect, so this block sees
    // exactly what the block saw. A byte is noted before a result is checked,
    // although a byte's own results never come out at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_byte(i_data);
            if (o_valid && i_ready)
                sb.check_result(o_result);
        end
    end

    // Receiver: takes results with random idle cycles, none during the quiet
    // stretch, and none at all while the long hold-off is in force.
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (hold_rx)
                i_ready <= 1'b0;
            else
                i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            @(posedge i_clk);
        end
    end

    // The long hold-off. The sender keeps offering bytes the whole time, so
    // the result register and the input register fill and o_ready drops.
    initial begin
        wait (bytes_sent >= 90);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("utf8_stream_validator_tb failed");
        $finish;
    end

    // Offers one byte and returns in the time step of the edge that took it.
    // Valid is lowered only when an idle gap follows, so it is never lowered
    // and raised again within one step.
    task automatic send_byte(input logic [7:0] b, input bit last_flag);
        utfv_pkg::t_in item;
        item.data_byte     = b;
        item.end_of_string = last_flag;
        no_idle <= (bytes_sent >= 150 && bytes_sent < 230);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < 30);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do
            @(posedge i_clk);
        while (!o_ready);
        bytes_sent++;
    endtask

    // Sends a whole buffer with the last byte marked.
    task automatic send_buffer(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    // A lead byte for a sequence of len bytes with random payload bits.
    function automatic logic [7:0] lead_byte(int len);
        logic [7:0] prefix;
        prefix = 8'hFF << (8 - len);
        return prefix | (8'($urandom()) & (8'h7F >> len));
    endfunction

    function automatic logic [7:0] cont_byte();
        return utfv_pkg::CONT_TAG | (8'($urandom()) & utfv_pkg::PAYLOAD_MASK);
    endfunction

    // Builds one random string buffer. Most characters are well formed with
    // random content; the rest are very long leads, cut-short sequences,
    // stray continuations, raw noise, embedded NULs and endings in the middle
    // of a sequence.
    task automatic send_random_string();
        logic [7:0] seq[$];
        int         n_chars;
        int         pick;
        int         len;
        int         keep;
        bit         done;
        n_chars = ($urandom_range(7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 10);
        done    = 1'b0;
        for (int c = 0; c < n_chars && !done; c++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                len = $urandom_range(1, 6);
                if (len == 1)
                    seq.push_back(8'($urandom_range(1, 127)));
                else begin
                    seq.push_back(lead_byte(len));
                    repeat (len - 1) seq.push_back(cont_byte());
                end
            end else if (pick < 65) begin
                // 0xFE takes six continuation bytes, 0xFF seven.
                if ($urandom_range(1)) begin
                    seq.push_back(8'hFF);
                    repeat (7) seq.push_back(cont_byte());
                end else begin
                    seq.push_back(8'hFE);
                    repeat (6) seq.push_back(cont_byte());
                end
            end else if (pick < 73) begin
                // Sequence cut short; whatever comes next interrupts it.
                len  = $urandom_range(2, 6);
                keep = $urandom_range(0, len - 2);
                seq.push_back(lead_byte(len));
                repeat (keep) seq.push_back(cont_byte());
            end else if (pick < 81) begin
                seq.push_back(cont_byte());
            end else if (pick < 88) begin
                seq.push_back(8'($urandom()));
            end else if (pick < 93) begin
                // Embedded NUL: the few bytes after it are skipped.
                seq.push_back(8'h00);
                repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom()));
                done = 1'b1;
            end else begin
                // The buffer ends in the middle of a sequence.
                len  = $urandom_range(2, 8);
                seq.push_back(len == 8 ? 8'hFF : (len == 7 ? 8'hFE : lead_byte(len)));
                repeat ($urandom_range(0, len - 2)) seq.push_back(cont_byte());
                done = 1'b1;
            end
        end
        // Some buffers carry a C-style terminator on their marked byte.
        if (!done && $urandom_range(9) < 3)
            seq.push_back(8'h00);
        send_buffer(seq);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Highest ASCII byte, a stray continuation, a two-byte sequence cut
        // short by an ASCII byte, the largest six-byte codepoint, and a
        // buffer that ends in the middle of a three-byte sequence.
        send_buffer('{8'h7F, 8'h80, 8'hC3, 8'h41,
                      8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                      8'hE2, 8'h82});
        // The 0xFF lead with all seven continuation bytes is malformed.
        send_buffer('{8'hFF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80});
        // A NUL that is not marked last: the rest of the buffer is skipped.
        send_buffer('{8'h00, 8'h41, 8'hC3});
        // A NUL that is itself the marked byte.
        send_buffer('{8'h00});

        while (bytes_sent < 24 + RANDOM_BYTES)
            send_random_string();

        // This runs in the step of the last transfer, where valid has no
        // other pending update.
        i_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.n_errors == 0)
            $display("utf8_stream_validator_tb passed");
        else
            $display("utf8_stream_validator_tb failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/utfv_pkg.sv
hdl/utfv_step.sv
hdl/utfv_outbuf.sv
hdl/utf8_stream_validator.sv
dv/utf8_stream_validator_tb.sv
